// File: sv/bh_pkg.sv
// Shared types, constants and helper functions for the byte histogram.
package bh_pkg;

  localparam int NUM_BINS    = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int BIN_AW      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int VALUE_W     = 8;
  localparam int OUT_CNT_W   = 32;

  typedef enum logic {
    OP_COUNT = 1'b0,
    OP_READ  = 1'b1
  } bh_op_t;

  typedef struct packed {
    bh_op_t             op;
    logic [VALUE_W-1:0] value;
  } bh_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   bin_index;
    logic [OUT_CNT_W-1:0] bin_count;
  } bh_out_t;

  typedef logic [COUNT_WIDTH-1:0] bh_cnt_t;
  typedef logic [BIN_AW-1:0]      bh_addr_t;

  // Write port of the bin store, driven by the update logic.
  typedef struct packed {
    logic     en;
    bh_addr_t addr;
    bh_cnt_t  data;
  } bh_ram_wr_t;

  function automatic logic in_range(input logic [VALUE_W-1:0] value);
    return 32'(value) < 32'(NUM_BINS);
  endfunction

  function automatic bh_addr_t bin_addr(input logic [VALUE_W-1:0] value);
    return BIN_AW'(value);
  endfunction

  // Increment that sticks at the largest representable count.
  function automatic bh_cnt_t sat_inc(input bh_cnt_t cnt);
    return (cnt == {COUNT_WIDTH{1'b1}}) ? cnt : cnt + COUNT_WIDTH'(1);
  endfunction

  // Clamp a stored count to the width of the result field.
  function automatic logic [OUT_CNT_W-1:0] sat_out(input bh_cnt_t cnt);
    logic [63:0] wide;
    wide = 64'(cnt);
    return (wide > 64'h0000_0000_FFFF_FFFF) ? {OUT_CNT_W{1'b1}} : OUT_CNT_W'(wide);
  endfunction

endpackage

// File: sv/bh_bin_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bh_bin_ram #(
  parameter int Depth = 256,
  parameter int Width = 32,
  parameter int Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [Aw-1:0]    wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic             rd_en,
  input  logic [Aw-1:0]    rd_addr,
  output logic [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/bh_rmw.sv
// Read-modify-write control for the bin store: entry valid bits, forwarding, result register.
module bh_rmw (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  bh_pkg::bh_in_t  in_data,
  output logic            rd_en,
  output bh_pkg::bh_addr_t rd_addr,
  input  bh_pkg::bh_cnt_t rd_data,
  output bh_pkg::bh_ram_wr_t ram_wr,
  output logic            out_valid,
  output bh_pkg::bh_out_t out_data
);
  import bh_pkg::*;

  // Entries never written since reset read as zero.
  logic [NUM_BINS-1:0] ent_vld_r, ent_vld_nxt;

  logic               s1_vld_r;
  bh_op_t             s1_op_r;
  logic [VALUE_W-1:0] s1_idx_r;
  bh_addr_t           s1_addr_r;
  logic               s1_inrng_r;
  logic               s1_ent_vld_r;
  logic               s1_fwd_r;
  bh_cnt_t            s1_fwd_data_r;

  logic               out_valid_r;
  bh_out_t            out_data_r;

  bh_addr_t   acc_addr;
  bh_cnt_t    cur_cnt;
  bh_ram_wr_t wr;

  assign acc_addr = bin_addr(in_data.value);
  assign rd_en    = accept;
  assign rd_addr  = acc_addr;

  // The beat in the update stage writes at the same edge the next beat reads,
  // so a matching address takes the value being written instead of the RAM.
  always_comb begin
    if (s1_fwd_r) begin
      cur_cnt = s1_fwd_data_r;
    end else if (s1_ent_vld_r) begin
      cur_cnt = rd_data;
    end else begin
      cur_cnt = '0;
    end
  end

  always_comb begin
    wr.en   = s1_vld_r && s1_inrng_r;
    wr.addr = s1_addr_r;
    case (s1_op_r)
      OP_COUNT: wr.data = sat_inc(cur_cnt);
      OP_READ:  wr.data = '0;
      default:  wr.data = '0;
    endcase
  end

  assign ram_wr = wr;

  always_comb begin
    ent_vld_nxt = ent_vld_r;
    if (wr.en) begin
      ent_vld_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r   <= '0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ent_vld_r   <= ent_vld_nxt;
      s1_vld_r    <= accept;
      out_valid_r <= s1_vld_r && (s1_op_r == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r       <= in_data.op;
      s1_idx_r      <= in_data.value;
      s1_addr_r     <= acc_addr;
      s1_inrng_r    <= in_range(in_data.value);
      s1_ent_vld_r  <= ent_vld_r[acc_addr];
      s1_fwd_r      <= wr.en && (wr.addr == acc_addr);
      s1_fwd_data_r <= wr.data;
    end
    if (s1_vld_r) begin
      out_data_r.bin_index <= s1_idx_r;
      out_data_r.bin_count <= s1_inrng_r ? sat_out(cur_cnt) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/byte_histogram_top.sv
// Top level of the byte histogram: bin store RAM and its read-modify-write control.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+-------------------------------------
//   input    | start, busy, in_data     | beat taken when start && !busy
//   result   | out_valid, out_data      | one-cycle strobe, cannot be held off
//
// One beat is taken per cycle while busy is low; busy is high only in reset and the cycle after.
// A read beat's result passes the registered RAM read, taken with the update-stage registers,
// and then the result register.
// The RAM write port closes the read-modify-write; back-to-back beats on the same
// bin are resolved by forwarding the value being written.
// Reset clears the per-entry valid bits at once, so no clearing pass is needed.
module byte_histogram_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  bh_pkg::bh_in_t  in_data,
  output logic            out_valid,
  output bh_pkg::bh_out_t out_data
);
  import bh_pkg::*;

  logic       busy_r;
  logic       accept;
  logic       rd_en;
  bh_addr_t   rd_addr;
  bh_cnt_t    rd_data;
  bh_ram_wr_t ram_wr;

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  bh_rmw u_rmw (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .ram_wr    (ram_wr),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  bh_bin_ram #(
    .Depth (NUM_BINS),
    .Width (COUNT_WIDTH),
    .Aw    (BIN_AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: sv/bh_checker.sv
// Port-level checker for the byte histogram, bound to the top level.
module bh_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input bh_pkg::bh_in_t  in_data,
  input logic            out_valid,
  input bh_pkg::bh_out_t out_data
);
  import bh_pkg::*;

  logic acc_read;
  logic acc_count;

  assign acc_read  = start && !busy && (in_data.op == OP_READ);
  assign acc_count = start && !busy && (in_data.op == OP_COUNT);

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc_read |-> ##2 out_valid)
    else $error("read beat did not produce a result");

  a_count_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc_count |-> ##2 !out_valid)
    else $error("count beat produced a result");

  a_index_echo: assert property (@(posedge clk) disable iff (!rst_n)
    acc_read |-> ##2 (out_data.bin_index == $past(in_data.value, 2)))
    else $error("result index does not match the read beat");

  a_reread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && (out_data.bin_index == $past(out_data.bin_index)))
      |-> (out_data.bin_count == '0))
    else $error("bin not cleared by the preceding read");

endmodule

bind byte_histogram_top bh_checker u_bh_checker (.*);

// File: bench/byte_histogram_top_tb.sv
// Self-checking testbench for the byte histogram: count and read/clear beats against a bin model.
`timescale 1ns / 1ps

module byte_histogram_top_tb;

  import bh_pkg::*;

  localparam int RANDOM_BEATS  = 950;
  localparam int DRAIN_AT      = 475;
  localparam int TAIL_BEATS    = 200;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_LIMIT   = 100;

  typedef struct {
    bh_in_t beat;
    bit     drain_first;
  } sample_beat_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  bh_in_t  in_data = '0;
  logic    out_valid;
  bh_out_t out_data;

  sample_beat_t sample_q[$];
  sample_beat_t next_beat;
  bh_out_t      readout_q[$];
  bh_out_t      want;
  bh_cnt_t      bin_model [NUM_BINS];

  bit driver_done = 1'b0;
  int gap_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;

  byte_histogram_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic queue_beat(input bh_op_t op, input logic [VALUE_W-1:0] value,
                            input bit drain_first);
    sample_beat_t s;
    s.beat.op = op;
    s.beat.value = value;
    s.drain_first = drain_first;
    sample_q.push_back(s);
  endtask

  // Applies one accepted beat to the bin model; a read also queues the expected readout.
  task automatic histogram_update(input bh_in_t beat);
    bh_out_t     res;
    logic [63:0] held;
    bit          in_bins;
    in_bins = int'(beat.value) < NUM_BINS;
    if (beat.op == OP_COUNT) begin
      if (in_bins && bin_model[beat.value] != '1) begin
        bin_model[beat.value] += COUNT_WIDTH'(1);
      end
    end else begin
      held = '0;
      if (in_bins) begin
        held = 64'(bin_model[beat.value]);
        bin_model[beat.value] = '0;
      end
      res.bin_index = beat.value;
      res.bin_count = (held > 64'h0000_0000_FFFF_FFFF) ? '1 : held[OUT_CNT_W-1:0];
      readout_q.push_back(res);
    end
  endtask

  // Stimulus: a short directed part, random histogram traffic, then a sweep reading every bin.
  initial begin
    int n;
    int run;
    bh_op_t op;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] hot_base;

    queue_beat(OP_COUNT, 8'h00, 1'b0);
    queue_beat(OP_COUNT, 8'hFF, 1'b0);
    queue_beat(OP_COUNT, 8'h55, 1'b0);
    queue_beat(OP_COUNT, 8'hAA, 1'b0);
    queue_beat(OP_COUNT, 8'h00, 1'b0);
    queue_beat(OP_READ, 8'h00, 1'b0);
    queue_beat(OP_READ, 8'h00, 1'b0);
    queue_beat(OP_READ, 8'hFF, 1'b0);
    queue_beat(OP_READ, 8'h55, 1'b0);
    queue_beat(OP_READ, 8'hAA, 1'b0);
    queue_beat(OP_READ, 8'h7F, 1'b0);
    // Back-to-back beats on one bin exercise the write forwarding path.
    repeat (3) queue_beat(OP_COUNT, 8'h33, 1'b0);
    queue_beat(OP_READ, 8'h33, 1'b0);
    queue_beat(OP_COUNT, 8'h33, 1'b0);
    queue_beat(OP_READ, 8'h33, 1'b0);
    queue_beat(OP_READ, 8'h33, 1'b0);
    queue_beat(OP_READ, 8'h44, 1'b0);
    queue_beat(OP_COUNT, 8'h44, 1'b0);
    queue_beat(OP_READ, 8'h44, 1'b0);
    // A full counter needs 2**32 - 1 count beats, so saturation is out of reach in this run.

    n = 0;
    hot_base = 8'($urandom_range(0, 255));
    while (n < RANDOM_BEATS) begin
      if ($urandom_range(0, 99) < 5) begin
        hot_base = 8'($urandom_range(0, 255));
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 6) : 1;
      op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_COUNT;
      if ($urandom_range(0, 1) == 1) begin
        value = 8'(hot_base + $urandom_range(0, 3));
      end else begin
        value = 8'($urandom_range(0, 255));
      end
      repeat (run) begin
        queue_beat(op, value, n == DRAIN_AT);
        n++;
      end
    end

    for (int b = 0; b < NUM_BINS && b < 256; b++) begin
      queue_beat(OP_READ, 8'(b), b == 0);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (!(driver_done && readout_q.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && readout_q.size() == 0) begin
      $display("byte_histogram_top regression: pass");
    end else begin
      $display("byte_histogram_top regression: fail");
    end
    $finish;
  end

  // Driver: a beat is taken at an edge where start is high and busy is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
      foreach (bin_model[i]) bin_model[i] = '0;
    end else begin
      if (start && !busy) begin
        histogram_update(in_data);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (sample_q.size() == 0) begin
          start <= 1'b0;
          driver_done <= 1'b1;
        end else if (sample_q[0].drain_first && readout_q.size() != 0) begin
          start <= 1'b0;
        end else begin
          next_beat = sample_q.pop_front();
          in_data <= next_beat.beat;
          start <= 1'b1;
          if (sample_q.size() > TAIL_BEATS && $urandom_range(0, 7) == 0) begin
            gap_left <= $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // Monitor: every strobed readout must match the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (readout_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected readout bin %0d count %0d",
                                out_data.bin_index, out_data.bin_count));
      end else begin
        want = readout_q.pop_front();
        if (out_data.bin_index !== want.bin_index) begin
          flag_mismatch($sformatf("bin_index got %0d want %0d",
                                  out_data.bin_index, want.bin_index));
        end
        if (out_data.bin_count !== want.bin_count) begin
          flag_mismatch($sformatf("bin %0d bin_count got %0d want %0d",
                                  want.bin_index, out_data.bin_count, want.bin_count));
        end
      end
    end
  end

  // Watchdog: too many cycles without an accepted beat or a readout ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("byte_histogram_top regression: fail");
        $finish;
      end
    end
  end

endmodule
